// ===== hw/rtl/gds_pkg.sv =====
// Shared types, constants and calendar helpers for the date stepper.
// No dependencies; imported by gds_alu, gds_norm, gregorian_date_stepper, date_checker and testbench.
package gds_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DELTA_W = 18;
    localparam int unsigned ACC_W   = 19;   // signed day index plus delta
    localparam int unsigned IDX_W   = 17;   // unsigned day index 0..MAX_INDEX
    localparam int unsigned LEN_W   = 11;   // largest step operand: 1461

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd1800;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd2099;
    localparam logic [YEAR_W-1:0]  YEAR_1900 = 12'd1900;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [IDX_W-1:0]   MAX_INDEX = 17'd109572; // 2099-12-31

    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_DIFF    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FWD_CHUNK,
        ST_FWD_YEAR,
        ST_FWD_MONTH,
        ST_FWD_DAY,
        ST_APPLY,
        ST_CLAMP,
        ST_INV_CHUNK,
        ST_INV_YEAR,
        ST_INV_MONTH,
        ST_SUBTRACT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] b;
        logic                    sub;
    } alu_req_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] res;
        logic                    neg;
    } alu_rsp_t;

    // Valid for 1800..2099 only: 1800 and 1900 are the century non-leap years there.
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_MIN) && (y != YEAR_1900);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [YEAR_W-1:0] y,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            MONTH_FEB: len = leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic [YEAR_W-1:0] y);
        return leap_year(y) ? 11'd366 : 11'd365;
    endfunction

    // Four years starting at a multiple of four.
    function automatic logic [LEN_W-1:0] chunk_len(input logic [YEAR_W-1:0] y);
        return ((y == YEAR_MIN) || (y == YEAR_1900)) ? 11'd1460 : 11'd1461;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_stepper.sv =====
// Gregorian date stepper: holds one date in 1800-01-01..2099-12-31; set, advance, difference.
// Set loads the normalized date; advance and difference walk the shared adder through
// four-year chunks, then single years, then months.
// Throughput: one request at a time; the next one is taken while a result waits to be read.
// Reset (rst_n low, asynchronous): date 1800-01-01, sequencer idle, no result pending.
// Depends on gds_pkg, gds_alu, gds_norm.
module gregorian_date_stepper
    import gds_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [13:0]               year_in,
    input  logic [MONTH_W-1:0]        month_in,
    input  logic [DAY_W-1:0]          day_in,
    input  logic signed [DELTA_W-1:0] delta,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [YEAR_W-1:0]         year_out,
    output logic [MONTH_W-1:0]        month_out,
    output logic [DAY_W-1:0]          day_out,
    output logic signed [DELTA_W-1:0] days_between,
    output logic                      hit_limit
);

    // Sequencer state and control
    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   which_reg;        // 0: index the stored date, 1: index the given date
    logic   in_fire;
    logic   out_free;

    // Stored date
    logic [YEAR_W-1:0]  cur_year_reg;
    logic [MONTH_W-1:0] cur_month_reg;
    logic [DAY_W-1:0]   cur_day_reg;

    // Request payload, held for the whole walk
    logic [1:0]                cmd_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [YEAR_W-1:0]         gy_reg;
    logic [MONTH_W-1:0]        gm_reg;
    logic [DAY_W-1:0]          gd_reg;

    // Walk registers
    logic [YEAR_W-1:0]       yy_reg;
    logic [MONTH_W-1:0]      mm_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [IDX_W-1:0]        tmp_reg;
    logic                    hit_reg;

    // Result registers
    logic [YEAR_W-1:0]         year_out_reg;
    logic [MONTH_W-1:0]        month_out_reg;
    logic [DAY_W-1:0]          day_out_reg;
    logic signed [DELTA_W-1:0] between_out_reg;
    logic                      hit_out_reg;

    // Normalized request date
    logic [YEAR_W-1:0]  norm_year;
    logic [MONTH_W-1:0] norm_month;
    logic [DAY_W-1:0]   norm_day;

    // Target of the forward walk
    logic [YEAR_W-1:0]  ty;
    logic [MONTH_W-1:0] tm;
    logic [DAY_W-1:0]   td;

    logic chunk_fits;
    logic year_more;
    logic month_more;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    gds_norm u_norm (
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .year_norm  (norm_year),
        .month_norm (norm_month),
        .day_norm   (norm_day)
    );

    gds_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign year_out     = year_out_reg;
    assign month_out    = month_out_reg;
    assign day_out      = day_out_reg;
    assign days_between = between_out_reg;
    assign hit_limit    = hit_out_reg;

    assign ty = which_reg ? gy_reg : cur_year_reg;
    assign tm = which_reg ? gm_reg : cur_month_reg;
    assign td = which_reg ? gd_reg : cur_day_reg;

    // Forward walk: whole four-year chunks, then single years, then months
    assign chunk_fits = (ty >= (yy_reg + 12'd4));
    assign year_more  = (yy_reg < ty);
    assign month_more = (mm_reg < tm);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_SET:     state_next = ST_LOAD;
                        CMD_ADVANCE: state_next = ST_FWD_CHUNK;
                        CMD_DIFF:    state_next = ST_FWD_CHUNK;
                        default:     state_next = ST_DONE;   // unused code: report date
                    endcase
                end
            end
            ST_LOAD:      state_next = ST_DONE;
            ST_FWD_CHUNK: state_next = chunk_fits ? ST_FWD_CHUNK : ST_FWD_YEAR;
            ST_FWD_YEAR:  state_next = year_more ? ST_FWD_YEAR : ST_FWD_MONTH;
            ST_FWD_MONTH: state_next = month_more ? ST_FWD_MONTH : ST_FWD_DAY;
            ST_FWD_DAY:
            begin
                if (cmd_reg == CMD_ADVANCE)
                begin
                    state_next = ST_APPLY;
                end
                else if (!which_reg)
                begin
                    state_next = ST_FWD_CHUNK;   // now index the given date
                end
                else
                begin
                    state_next = ST_SUBTRACT;
                end
            end
            ST_APPLY:     state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_INV_CHUNK;
            ST_INV_CHUNK: state_next = alu_rsp.neg ? ST_INV_YEAR : ST_INV_CHUNK;
            ST_INV_YEAR:  state_next = alu_rsp.neg ? ST_INV_MONTH : ST_INV_YEAR;
            ST_INV_MONTH: state_next = alu_rsp.neg ? ST_DONE : ST_INV_MONTH;
            ST_SUBTRACT:  state_next = ST_DONE;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Shared adder operand select
    always_comb
    begin
        alu_req.a   = acc_reg;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            ST_FWD_CHUNK:
            begin
                alu_req.b = $signed({{(ACC_W-LEN_W){1'b0}}, chunk_len(yy_reg)});
            end
            ST_FWD_YEAR:
            begin
                alu_req.b = $signed({{(ACC_W-LEN_W){1'b0}}, year_len(yy_reg)});
            end
            ST_FWD_MONTH:
            begin
                alu_req.b = $signed({{(ACC_W-DAY_W){1'b0}}, month_len(ty, mm_reg)});
            end
            ST_FWD_DAY:
            begin
                alu_req.b = $signed({{(ACC_W-DAY_W){1'b0}}, td - 5'd1});
            end
            ST_APPLY:
            begin
                alu_req.b = $signed({delta_reg[DELTA_W-1], delta_reg});
            end
            ST_INV_CHUNK:
            begin
                alu_req.b   = $signed({{(ACC_W-LEN_W){1'b0}}, chunk_len(yy_reg)});
                alu_req.sub = 1'b1;
            end
            ST_INV_YEAR:
            begin
                alu_req.b   = $signed({{(ACC_W-LEN_W){1'b0}}, year_len(yy_reg)});
                alu_req.sub = 1'b1;
            end
            ST_INV_MONTH:
            begin
                alu_req.b   = $signed({{(ACC_W-DAY_W){1'b0}}, month_len(yy_reg, mm_reg)});
                alu_req.sub = 1'b1;
            end
            ST_SUBTRACT:
            begin
                // stored date index minus given date index
                alu_req.a   = $signed({{(ACC_W-IDX_W){1'b0}}, tmp_reg});
                alu_req.b   = acc_reg;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.b = '0;
            end
        endcase
    end

    // Control state and stored date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_year_reg  <= YEAR_MIN;
            cur_month_reg <= MONTH_JAN;
            cur_day_reg   <= 5'd1;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_LOAD)
            begin
                cur_year_reg  <= gy_reg;
                cur_month_reg <= gm_reg;
                cur_day_reg   <= gd_reg;
            end
            else if ((state_reg == ST_INV_MONTH) && alu_rsp.neg)
            begin
                // remainder is the zero-based day of the month
                cur_year_reg  <= yy_reg;
                cur_month_reg <= mm_reg;
                cur_day_reg   <= acc_reg[DAY_W-1:0] + 5'd1;
            end
        end
    end

    // Walk datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_reg   <= cmd;
                    delta_reg <= delta;
                    gy_reg    <= norm_year;
                    gm_reg    <= norm_month;
                    gd_reg    <= norm_day;
                    yy_reg    <= YEAR_MIN;
                    mm_reg    <= MONTH_JAN;
                    acc_reg   <= '0;
                    which_reg <= 1'b0;
                    hit_reg   <= 1'b0;
                end
            end
            ST_FWD_CHUNK:
            begin
                if (chunk_fits)
                begin
                    acc_reg <= alu_rsp.res;
                    yy_reg  <= yy_reg + 12'd4;
                end
            end
            ST_FWD_YEAR:
            begin
                if (year_more)
                begin
                    acc_reg <= alu_rsp.res;
                    yy_reg  <= yy_reg + 12'd1;
                end
            end
            ST_FWD_MONTH:
            begin
                if (month_more)
                begin
                    acc_reg <= alu_rsp.res;
                    mm_reg  <= mm_reg + 4'd1;
                end
            end
            ST_FWD_DAY:
            begin
                if ((cmd_reg == CMD_DIFF) && !which_reg)
                begin
                    // hold the stored date index, restart on the given date
                    tmp_reg   <= alu_rsp.res[IDX_W-1:0];
                    which_reg <= 1'b1;
                    yy_reg    <= YEAR_MIN;
                    mm_reg    <= MONTH_JAN;
                    acc_reg   <= '0;
                end
                else
                begin
                    acc_reg <= alu_rsp.res;
                end
            end
            ST_APPLY:
            begin
                acc_reg <= alu_rsp.res;
            end
            ST_CLAMP:
            begin
                yy_reg <= YEAR_MIN;
                mm_reg <= MONTH_JAN;
                if (acc_reg < 0)
                begin
                    acc_reg <= '0;
                    hit_reg <= 1'b1;
                end
                else if (acc_reg > $signed({{(ACC_W-IDX_W){1'b0}}, MAX_INDEX}))
                begin
                    acc_reg <= $signed({{(ACC_W-IDX_W){1'b0}}, MAX_INDEX});
                    hit_reg <= 1'b1;
                end
            end
            ST_INV_CHUNK:
            begin
                if (!alu_rsp.neg)
                begin
                    acc_reg <= alu_rsp.res;
                    yy_reg  <= yy_reg + 12'd4;
                end
            end
            ST_INV_YEAR:
            begin
                if (!alu_rsp.neg)
                begin
                    acc_reg <= alu_rsp.res;
                    yy_reg  <= yy_reg + 12'd1;
                end
            end
            ST_INV_MONTH:
            begin
                if (!alu_rsp.neg)
                begin
                    acc_reg <= alu_rsp.res;
                    mm_reg  <= mm_reg + 4'd1;
                end
            end
            ST_SUBTRACT:
            begin
                acc_reg <= alu_rsp.res;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Result register: load once the previous result has been taken
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            year_out_reg    <= cur_year_reg;
            month_out_reg   <= cur_month_reg;
            day_out_reg     <= cur_day_reg;
            between_out_reg <= (cmd_reg == CMD_DIFF) ? acc_reg[DELTA_W-1:0] : '0;
            hit_out_reg     <= (cmd_reg == CMD_ADVANCE) ? hit_reg : 1'b0;
        end
    end

`ifndef SYNTH
    // Stored date stays a valid calendar date in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_year_reg >= YEAR_MIN) && (cur_year_reg <= YEAR_MAX)
        && (cur_month_reg >= MONTH_JAN) && (cur_month_reg <= MONTH_DEC)
        && (cur_day_reg != '0)
        && (cur_day_reg <= month_len(cur_year_reg, cur_month_reg)))
        else $error("stored date out of range");

    // Inverse walk only sees a saturated index
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_INV_CHUNK) || (state_reg == ST_INV_YEAR)
         || (state_reg == ST_INV_MONTH))
        |-> ((acc_reg >= 0)
             && (acc_reg <= $signed({{(ACC_W-IDX_W){1'b0}}, MAX_INDEX}))))
        else $error("inverse walk index out of range");

    // Inverse chunk walk never runs past the last chunk
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INV_CHUNK) |-> (yy_reg <= YEAR_MAX))
        else $error("inverse walk past last year");

    // A taken request blocks the input until its result is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("request taken while busy");

    // A finished result reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (out_valid && in_ready))
        else $error("result not issued");
`endif

endmodule

// ===== hw/rtl/gds_alu.sv =====
// Shared add/subtract unit of the date stepper sequencer.
// Depends on gds_pkg.
module gds_alu
    import gds_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic signed [ACC_W-1:0] sum;

    assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
    assign rsp.res = sum;
    assign rsp.neg = sum[ACC_W-1];

endmodule

// ===== hw/rtl/gds_norm.sv =====
// Date normalization: century expansion, year/month clamp, day clamp to 1..month length.
// Depends on gds_pkg.
module gds_norm
    import gds_pkg::*;
(
    input  logic [13:0]        year_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [DAY_W-1:0]   day_in,
    output logic [YEAR_W-1:0]  year_norm,
    output logic [MONTH_W-1:0] month_norm,
    output logic [DAY_W-1:0]   day_norm
);

    logic [13:0]      year_exp;
    logic [DAY_W-1:0] len;

    always_comb
    begin
        if (year_in < 14'd50)
        begin
            year_exp = year_in + 14'd2000;
        end
        else if (year_in < 14'd100)
        begin
            year_exp = year_in + 14'd1900;
        end
        else
        begin
            year_exp = year_in;
        end

        if (year_exp < {2'b00, YEAR_MIN})
        begin
            year_norm = YEAR_MIN;
        end
        else if (year_exp > {2'b00, YEAR_MAX})
        begin
            year_norm = YEAR_MAX;
        end
        else
        begin
            year_norm = year_exp[YEAR_W-1:0];
        end

        if (month_in < MONTH_JAN)
        begin
            month_norm = MONTH_JAN;
        end
        else if (month_in > MONTH_DEC)
        begin
            month_norm = MONTH_DEC;
        end
        else
        begin
            month_norm = month_in;
        end

        len = month_len(year_norm, month_norm);

        if (day_in == '0)
        begin
            day_norm = 5'd1;
        end
        else if (day_in > len)
        begin
            day_norm = len;
        end
        else
        begin
            day_norm = day_in;
        end
    end

endmodule

// ===== bench/date_checker.sv =====
// Checker for the date stepper: watches the request and reply channels, predicts each reply
// from its own calendar arithmetic and compares it field by field with what comes out.
// Depends on gds_pkg for widths and command codes.
module date_checker
    import gds_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [13:0]               year_in,
    input  logic [MONTH_W-1:0]        month_in,
    input  logic [DAY_W-1:0]          day_in,
    input  logic signed [DELTA_W-1:0] delta,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [YEAR_W-1:0]         year_out,
    input  logic [MONTH_W-1:0]        month_out,
    input  logic [DAY_W-1:0]          day_out,
    input  logic signed [DELTA_W-1:0] days_between,
    input  logic                      hit_limit,
    output int                        mismatches,
    output int                        open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIRST_YEAR  = int'(YEAR_MIN);
    localparam int LAST_YEAR   = int'(YEAR_MAX);
    localparam int LAST_NUMBER = int'(MAX_INDEX);

    typedef struct packed {
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
    } cal_date_t;

    typedef struct packed {
        cal_date_t                 date;
        logic signed [DELTA_W-1:0] between;
        logic                      hit;
    } reply_t;

    cal_date_t held;
    reply_t    due_replies[$];
    int        replies_seen;

    function automatic bit is_leap(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int days_of_month(input int y, input int m);
        int len;
        case (m)
            2:             len = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    // Days elapsed since the first day of the range.
    function automatic int day_number(input cal_date_t dt);
        int n;
        int yy;
        int mm;
        n = 0;
        for (yy = FIRST_YEAR; yy < int'(dt.y); yy++)
            n += is_leap(yy) ? 366 : 365;
        for (mm = 1; mm < int'(dt.m); mm++)
            n += days_of_month(int'(dt.y), mm);
        return n + int'(dt.d) - 1;
    endfunction

    function automatic cal_date_t date_of_number(input int n);
        int        yy;
        int        mm;
        cal_date_t dt;
        yy = FIRST_YEAR;
        while (n >= (is_leap(yy) ? 366 : 365)) begin
            n -= is_leap(yy) ? 366 : 365;
            yy++;
        end
        mm = 1;
        while (n >= days_of_month(yy, mm)) begin
            n -= days_of_month(yy, mm);
            mm++;
        end
        dt.y = YEAR_W'(yy);
        dt.m = MONTH_W'(mm);
        dt.d = DAY_W'(n + 1);
        return dt;
    endfunction

    // Expand two-digit years, then clamp year, month and day in that order.
    function automatic cal_date_t tidy_date(input int y, input int m, input int d);
        cal_date_t dt;
        int        len;
        if (y < 100)
            y += (y < 50) ? 2000 : 1900;
        if (y < FIRST_YEAR)
            y = FIRST_YEAR;
        if (y > LAST_YEAR)
            y = LAST_YEAR;
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        len = days_of_month(y, m);
        if (d < 1)
            d = 1;
        if (d > len)
            d = len;
        dt.y = YEAR_W'(y);
        dt.m = MONTH_W'(m);
        dt.d = DAY_W'(d);
        return dt;
    endfunction

    // Apply one request to the held date and return the reply it must produce.
    function automatic reply_t step_calendar(input logic [1:0] op, input logic [13:0] yr,
                                             input logic [MONTH_W-1:0] mo,
                                             input logic [DAY_W-1:0] dy,
                                             input logic signed [DELTA_W-1:0] step);
        reply_t    r;
        cal_date_t given;
        int        n;
        r.between = '0;
        r.hit     = 1'b0;
        case (op)
            CMD_SET:
                held = tidy_date(int'(yr), int'(mo), int'(dy));
            CMD_ADVANCE:
            begin
                n = day_number(held) + int'(step);
                if (n < 0)
                begin
                    n     = 0;
                    r.hit = 1'b1;
                end
                if (n > LAST_NUMBER)
                begin
                    n     = LAST_NUMBER;
                    r.hit = 1'b1;
                end
                held = date_of_number(n);
            end
            CMD_DIFF:
            begin
                given     = tidy_date(int'(yr), int'(mo), int'(dy));
                r.between = DELTA_W'(day_number(held) - day_number(given));
            end
            default: ;
        endcase
        r.date = held;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("[%0t] reply %0d: %s", $time, replies_seen, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            held.y = YEAR_MIN;
            held.m = MONTH_JAN;
            held.d = DAY_W'(1);
            due_replies.delete();
            mismatches   = 0;
            replies_seen = 0;
        end
        else
        begin
            // check the reply first: a request taken at this edge cannot answer at it
            if (out_valid && out_ready)
            begin
                if (due_replies.size() == 0)
                    report_mismatch("reply with no request outstanding");
                else
                begin
                    want = due_replies.pop_front();
                    if (year_out !== want.date.y)
                        report_mismatch($sformatf("year_out %0d, predicted %0d",
                                                  year_out, want.date.y));
                    if (month_out !== want.date.m)
                        report_mismatch($sformatf("month_out %0d, predicted %0d",
                                                  month_out, want.date.m));
                    if (day_out !== want.date.d)
                        report_mismatch($sformatf("day_out %0d, predicted %0d",
                                                  day_out, want.date.d));
                    if (days_between !== want.between)
                        report_mismatch($sformatf("days_between %0d, predicted %0d",
                                                  days_between, want.between));
                    if (hit_limit !== want.hit)
                        report_mismatch($sformatf("hit_limit %0b, predicted %0b",
                                                  hit_limit, want.hit));
                end
                replies_seen++;
            end
            if (in_valid && in_ready)
                due_replies.push_back(step_calendar(cmd, year_in, month_in, day_in, delta));
        end
        open_count <= due_replies.size();
    end

endmodule

// ===== bench/testbench.sv =====
// Top of the date stepper bench: clock, reset, request stimulus and the verdict.
// Instantiates gregorian_date_stepper and date_checker; depends on gds_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gds_pkg::*;

    // Command code the block does not define; it must leave the date alone.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Settle time after the final drain, before the verdict.
    localparam int SETTLE_CYCLES = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 256;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                cmd;
    logic [13:0]               year_in;
    logic [MONTH_W-1:0]        month_in;
    logic [DAY_W-1:0]          day_in;
    logic signed [DELTA_W-1:0] delta;
    logic                      out_valid;
    logic                      out_ready;
    logic [YEAR_W-1:0]         year_out;
    logic [MONTH_W-1:0]        month_out;
    logic [DAY_W-1:0]          day_out;
    logic signed [DELTA_W-1:0] days_between;
    logic                      hit_limit;

    int mismatches;
    int open_count;

    // Idle and stall odds in percent; hold_req asks the receiver for one long hold-off.
    int idle_pct;
    int stall_pct;
    bit hold_req;

    gregorian_date_stepper u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .year_in      (year_in),
        .month_in     (month_in),
        .day_in       (day_in),
        .delta        (delta),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .days_between (days_between),
        .hit_limit    (hit_limit)
    );

    date_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .year_in      (year_in),
        .month_in     (month_in),
        .day_in       (day_in),
        .delta        (delta),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .year_out     (year_out),
        .month_out    (month_out),
        .day_out      (day_out),
        .days_between (days_between),
        .hit_limit    (hit_limit),
        .mismatches   (mismatches),
        .open_count   (open_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #2_400_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stall at the current odds; on request, hold off once for a long
    // stretch so the block fills up and pushes back on its input.
    initial
    begin
        bit hold_used;
        hold_used = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one request. Call right after a rising edge; returns right after the
    // edge that takes it. Drop valid only when an idle gap is drawn, so valid is
    // never lowered and raised in the same step.
    task automatic offer(input logic [1:0] op, input int yr, input int mo, input int dy,
                         input int step);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        year_in  <= 14'(yr);
        month_in <= MONTH_W'(mo);
        day_in   <= DAY_W'(dy);
        delta    <= DELTA_W'(step);
        // sample in_ready as it stood before the edge
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold until every reply has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_count != 0);
    endtask

    // Mostly plausible dates and short steps so that month and year edges and the
    // range ends get hit often; the rest spans the full width of every field.
    task automatic random_request();
        int         pick;
        int         yr;
        int         mo;
        int         dy;
        int         step;
        logic [1:0] op;
        pick = int'($urandom_range(99));
        if (pick < 25)
            op = CMD_SET;
        else if (pick < 70)
            op = CMD_ADVANCE;
        else if (pick < 95)
            op = CMD_DIFF;
        else
            op = CMD_SPARE;
        pick = int'($urandom_range(99));
        if (pick < 50)
            yr = 1800 + int'($urandom_range(299));
        else if (pick < 62)
            yr = ($urandom_range(1) == 0) ? 1800 : 2099;
        else if (pick < 80)
            yr = int'($urandom_range(99));
        else
            yr = int'($urandom_range(16383));
        mo = ($urandom_range(99) < 85) ? 1 + int'($urandom_range(11)) : int'($urandom_range(15));
        dy = ($urandom_range(99) < 85) ? 1 + int'($urandom_range(30)) : int'($urandom_range(31));
        pick = int'($urandom_range(99));
        if (pick < 50)
            step = int'($urandom_range(80)) - 40;
        else if (pick < 75)
            step = int'($urandom_range(3000)) - 1500;
        else if (pick < 90)
            step = int'($urandom_range(80000)) - 40000;
        else
            step = int'($urandom());
        offer(op, yr, mo, dy, step);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_SET;
        year_in   <= '0;
        month_in  <= '0;
        day_in    <= '0;
        delta     <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, back to back.
        // Unused code straight after reset: reports the reset date, fields all ones.
        offer(CMD_SPARE, 16383, 15, 31, -1);
        offer(CMD_DIFF, 1800, 1, 1, 0);
        // Two-digit years on both sides of the pivot, with month and day clamping.
        offer(CMD_SET, 0, 0, 0, 131071);
        offer(CMD_SET, 49, 2, 30, 0);
        offer(CMD_SET, 50, 13, 0, 0);
        offer(CMD_SET, 99, 2, 29, 0);
        offer(CMD_SET, 100, 6, 31, 0);
        // Century years: 1900 is common, 2000 is leap.
        offer(CMD_SET, 1900, 2, 29, 0);
        offer(CMD_SET, 2000, 2, 31, 0);
        // Advance ignores the date fields; step across the leap day both ways.
        offer(CMD_ADVANCE, 16383, 15, 31, 1);
        offer(CMD_ADVANCE, 0, 0, 0, -1);
        // Upper range end: zero step, then one past it saturates.
        offer(CMD_SET, 16383, 15, 31, 0);
        offer(CMD_ADVANCE, 0, 0, 0, 0);
        offer(CMD_ADVANCE, 0, 0, 0, 1);
        offer(CMD_DIFF, 1800, 1, 1, 0);
        offer(CMD_DIFF, 9999, 12, 31, 0);
        // Land exactly on each end without saturating, then run past them.
        offer(CMD_ADVANCE, 0, 0, 0, -109572);
        offer(CMD_ADVANCE, 0, 0, 0, -1);
        offer(CMD_ADVANCE, 0, 0, 0, 109572);
        offer(CMD_ADVANCE, 0, 0, 0, -131072);
        offer(CMD_DIFF, 2099, 12, 31, 0);
        offer(CMD_ADVANCE, 0, 0, 0, 131071);
        offer(CMD_SET, 1800, 2, 29, 0);
        offer(CMD_SPARE, 0, 0, 0, 0);
        offer(CMD_SET, 1999, 12, 31, 0);
        offer(CMD_ADVANCE, 0, 0, 0, 1);
        drain();

        // Random requests in four idling phases; pause for all replies between them.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 79; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // keep offering while the receiver holds off
                if (phase == 0 && i == PHASE_ITEMS / 2)
                    hold_req = 1'b1;
                random_request();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
